// ===== hdl/rvx_pkg.sv =====
`timescale 1ns / 1ps
package rvx_pkg;

  localparam int RegCountDefault = 32;
  localparam int CsrCountDefault = 8;
  localparam int CsrMapDepth     = 16;

  typedef enum logic [5:0] {
    OP_ADD, OP_ADDI, OP_SUB, OP_XOR, OP_OR, OP_AND, OP_XORI, OP_ORI, OP_ANDI,
    OP_SLL, OP_SRL, OP_SRA, OP_SLLI, OP_SRLI, OP_SRAI, OP_SLT, OP_SLTU,
    OP_SLTI, OP_SLTIU, OP_LUI, OP_LW, OP_SW, OP_LB, OP_LBU, OP_SB, OP_LH,
    OP_LHU, OP_SH, OP_BEQ, OP_BNE, OP_BLT, OP_BGE, OP_BLTU, OP_BGEU,
    OP_AUIPC, OP_JAL, OP_JALR, OP_FENCE, OP_ECALL, OP_EBREAK, OP_CSRRW,
    OP_CSRRS, OP_CSRRC, OP_CSRRWI, OP_CSRRSI, OP_CSRRCI, OP_MRET
  } op_t;

  typedef enum logic [3:0] {
    CLS_ALU, CLS_LOAD, CLS_STORE, CLS_BRANCH, CLS_JUMP, CLS_CSR, CLS_MRET,
    CLS_SYS, CLS_RESP, CLS_ILLEGAL
  } cls_t;

  localparam logic [3:0] TRAP_NONE       = 4'd0;
  localparam logic [3:0] TRAP_ILLEGAL    = 4'd1;
  localparam logic [3:0] TRAP_FETCH_MIS  = 4'd2;
  localparam logic [3:0] TRAP_LOAD_MIS   = 4'd3;
  localparam logic [3:0] TRAP_LOAD_FLT   = 4'd4;
  localparam logic [3:0] TRAP_STORE_MIS  = 4'd5;
  localparam logic [3:0] TRAP_STORE_FLT  = 4'd6;
  localparam logic [3:0] TRAP_ECALL      = 4'd7;
  localparam logic [3:0] TRAP_BREAK      = 4'd8;

  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;
  localparam logic [1:0] SIZE_WORD = 2'd2;

  localparam logic [31:0] MSTATUS_MIE  = 32'h0000_0008;
  localparam logic [31:0] MSTATUS_MPIE = 32'h0000_0080;

  localparam logic [11:0] CSR_MAP [CsrMapDepth] = '{
    12'h300, 12'h341, 12'h305, 12'h342, 12'h343, 12'h304, 12'h344, 12'h340,
    12'h301, 12'h302, 12'h303, 12'h306, 12'hF11, 12'hF12, 12'hF13, 12'hF14
  };

  typedef struct packed {
    logic        action;
    logic [5:0]  operation;
    logic [4:0]  dest_reg;
    logic [4:0]  src1_reg;
    logic [4:0]  src2_reg;
    logic [31:0] immediate;
    logic [11:0] csr_address;
    logic [31:0] instruction_word;
    logic [31:0] current_pc;
    logic [31:0] mem_read_data;
    logic        mem_fault;
  } req_t;

  typedef struct packed {
    req_t item;
    cls_t cls;
  } item_t;

  typedef struct packed {
    logic        result_kind;
    logic        jump_valid;
    logic [31:0] next_pc;
    logic [3:0]  trap_cause;
    logic [31:0] trap_value;
    logic        mem_is_write;
    logic [1:0]  mem_size;
    logic [31:0] mem_address;
    logic [31:0] mem_write_data;
  } rsp_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] slot;
  } csr_hit_t;

  function automatic csr_hit_t csr_lookup(input logic [11:0] addr, input int count);
    csr_hit_t r;
    r = '0;
    for (int i = CsrMapDepth - 1; i >= 0; i--) begin
      if (i < count && CSR_MAP[i] == addr) begin
        r.hit  = 1'b1;
        r.slot = 4'(i);
      end
    end
    return r;
  endfunction

endpackage

// ===== hdl/rvx_if.sv =====
`timescale 1ns / 1ps
interface rvx_req_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [5:0]  operation;
  logic [4:0]  dest_reg;
  logic [4:0]  src1_reg;
  logic [4:0]  src2_reg;
  logic [31:0] immediate;
  logic [11:0] csr_address;
  logic [31:0] instruction_word;
  logic [31:0] current_pc;
  logic [31:0] mem_read_data;
  logic        mem_fault;
  modport source (output valid, action, operation, dest_reg, src1_reg, src2_reg,
                  immediate, csr_address, instruction_word, current_pc,
                  mem_read_data, mem_fault, input ready);
  modport sink (input valid, action, operation, dest_reg, src1_reg, src2_reg,
                immediate, csr_address, instruction_word, current_pc,
                mem_read_data, mem_fault, output ready);
endinterface

interface rvx_rsp_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic        jump_valid;
  logic [31:0] next_pc;
  logic [3:0]  trap_cause;
  logic [31:0] trap_value;
  logic        mem_is_write;
  logic [1:0]  mem_size;
  logic [31:0] mem_address;
  logic [31:0] mem_write_data;
  modport source (output valid, result_kind, jump_valid, next_pc, trap_cause,
                  trap_value, mem_is_write, mem_size, mem_address,
                  mem_write_data, input ready);
  modport sink (input valid, result_kind, jump_valid, next_pc, trap_cause,
                trap_value, mem_is_write, mem_size, mem_address,
                mem_write_data, output ready);
endinterface

// ===== hdl/rvx_front.sv =====
`timescale 1ns / 1ps
module rvx_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  rvx_pkg::req_t in_item,
  output logic          q_valid,
  input  logic          q_pop,
  output rvx_pkg::item_t q_item
);
  import rvx_pkg::*;

  item_t      q_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  cls_t       cls;
  logic       push, pop;

  always_comb begin
    if (in_item.action) begin
      cls = CLS_RESP;
    end else begin
      unique case (op_t'(in_item.operation)) inside
        [OP_ADD:OP_LUI], OP_AUIPC:          cls = CLS_ALU;
        OP_LW, OP_LB, OP_LBU, OP_LH, OP_LHU: cls = CLS_LOAD;
        OP_SW, OP_SB, OP_SH:                cls = CLS_STORE;
        [OP_BEQ:OP_BGEU]:                   cls = CLS_BRANCH;
        OP_JAL, OP_JALR:                    cls = CLS_JUMP;
        OP_FENCE, OP_ECALL, OP_EBREAK:      cls = CLS_SYS;
        [OP_CSRRW:OP_CSRRCI]:               cls = CLS_CSR;
        OP_MRET:                            cls = CLS_MRET;
        default:                            cls = CLS_ILLEGAL;
      endcase
    end
  end

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;
  assign q_item   = q_r[rp_r];
  assign wp_nxt   = wp_r ^ push;
  assign rp_nxt   = rp_r ^ pop;
  assign cnt_nxt  = cnt_r + 2'(push) - 2'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= '{item: in_item, cls: cls};
    end
  end
endmodule

// ===== hdl/rvx_back.sv =====
`timescale 1ns / 1ps
module rvx_back #(
  parameter int REG_COUNT = rvx_pkg::RegCountDefault,
  parameter int CSR_COUNT = rvx_pkg::CsrCountDefault
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  output logic           q_pop,
  input  rvx_pkg::item_t q_item,
  output logic           out_valid,
  input  logic           out_ready,
  output rvx_pkg::rsp_t  out_rsp
);
  import rvx_pkg::*;

  localparam int RW = $clog2(REG_COUNT);
  localparam int CW = $clog2(CSR_COUNT);
  localparam logic [5:0] REG_LIM = 6'(REG_COUNT);

  logic [31:0] rf [REG_COUNT];
  logic [REG_COUNT-1:0] rfv_r;
  logic [31:0] csr_r [CSR_COUNT];

  item_t       e_r;
  logic        e_valid_r;
  logic [31:0] rq1_r, rq2_r, byd_r;
  logic        vq1_r, vq2_r, by1_r, by2_r;

  logic        pend_v_r, pend_v_nxt;
  logic [5:0]  pend_op_r, pend_op_nxt;
  logic [4:0]  pend_rd_r, pend_rd_nxt;
  logic [31:0] pend_addr_r, pend_addr_nxt;

  rsp_t        out_r, res;
  logic        out_valid_r;

  logic        fire, out_free;
  logic        wr_en, wr_req;
  logic [4:0]  wr_idx;
  logic [31:0] wr_data;
  logic        csr_we;
  logic [CW-1:0] csr_idx;
  logic [31:0] csr_wdata;
  logic        ms_we;
  logic [31:0] ms_wdata;

  req_t        it;
  op_t         op;
  logic        ok1, ok2;
  logic [31:0] a, b, addr, tgt, old, src, d, ms;
  logic        taken, store, immf;
  csr_hit_t    ch;

  assign out_free = !out_valid_r || out_ready;
  assign fire     = e_valid_r && out_free;
  assign q_pop    = !e_valid_r || fire;
  assign out_valid = out_valid_r;
  assign out_rsp   = out_r;

  assign it  = e_r.item;
  assign op  = op_t'(it.operation);
  assign ok1 = (it.src1_reg != 5'd0) && ({1'b0, it.src1_reg} < REG_LIM);
  assign ok2 = (it.src2_reg != 5'd0) && ({1'b0, it.src2_reg} < REG_LIM);
  assign a = !ok1 ? 32'd0 : by1_r ? byd_r : vq1_r ? rq1_r : 32'd0;
  assign b = !ok2 ? 32'd0 : by2_r ? byd_r : vq2_r ? rq2_r : 32'd0;
  assign addr = a + it.immediate;
  assign ch   = csr_lookup(it.csr_address, CSR_COUNT);
  assign wr_en = fire && wr_req && (wr_idx != 5'd0) && ({1'b0, wr_idx} < REG_LIM);

  always_comb begin
    res = '0;
    wr_req = 1'b0;
    wr_idx = it.dest_reg;
    wr_data = '0;
    csr_we = 1'b0;
    csr_idx = ch.slot[CW-1:0];
    csr_wdata = '0;
    ms_we = 1'b0;
    ms_wdata = '0;
    pend_v_nxt = pend_v_r;
    pend_op_nxt = pend_op_r;
    pend_rd_nxt = pend_rd_r;
    pend_addr_nxt = pend_addr_r;
    taken = 1'b0;
    tgt = '0;
    old = '0;
    src = '0;
    d = it.mem_read_data;
    ms = csr_r[0];
    immf = 1'b0;
    store = (pend_op_r == OP_SW) || (pend_op_r == OP_SB) || (pend_op_r == OP_SH);
    unique case (e_r.cls)
      CLS_RESP: begin
        if (pend_v_r) begin
          pend_v_nxt = 1'b0;
          if (it.mem_fault) begin
            res.trap_cause = store ? TRAP_STORE_FLT : TRAP_LOAD_FLT;
            res.trap_value = pend_addr_r;
          end else if (!store) begin
            case (op_t'(pend_op_r))
              OP_LB:   d = {{24{d[7]}}, d[7:0]};
              OP_LBU:  d = {24'd0, d[7:0]};
              OP_LH:   d = {{16{d[15]}}, d[15:0]};
              OP_LHU:  d = {16'd0, d[15:0]};
              default: d = it.mem_read_data;
            endcase
            wr_req = 1'b1;
            wr_idx = pend_rd_r;
            wr_data = d;
          end
        end
      end
      CLS_ALU: begin
        wr_req = 1'b1;
        case (op)
          OP_ADD:   wr_data = a + b;
          OP_ADDI:  wr_data = addr;
          OP_SUB:   wr_data = a - b;
          OP_XOR:   wr_data = a ^ b;
          OP_OR:    wr_data = a | b;
          OP_AND:   wr_data = a & b;
          OP_XORI:  wr_data = a ^ it.immediate;
          OP_ORI:   wr_data = a | it.immediate;
          OP_ANDI:  wr_data = a & it.immediate;
          OP_SLL:   wr_data = a << b[4:0];
          OP_SRL:   wr_data = a >> b[4:0];
          OP_SRA:   wr_data = 32'($signed(a) >>> b[4:0]);
          OP_SLLI:  wr_data = a << it.immediate[4:0];
          OP_SRLI:  wr_data = a >> it.immediate[4:0];
          OP_SRAI:  wr_data = 32'($signed(a) >>> it.immediate[4:0]);
          OP_SLT:   wr_data = {31'd0, $signed(a) < $signed(b)};
          OP_SLTU:  wr_data = {31'd0, a < b};
          OP_SLTI:  wr_data = {31'd0, $signed(a) < $signed(it.immediate)};
          OP_SLTIU: wr_data = {31'd0, a < it.immediate};
          OP_LUI:   wr_data = it.immediate;
          default:  wr_data = it.current_pc + it.immediate;
        endcase
      end
      CLS_LOAD, CLS_STORE: begin
        res.mem_size = (op == OP_LW || op == OP_SW) ? SIZE_WORD :
                       (op == OP_LH || op == OP_LHU || op == OP_SH) ? SIZE_HALF :
                       SIZE_BYTE;
        if ((res.mem_size == SIZE_WORD && addr[1:0] != 2'd0) ||
            (res.mem_size == SIZE_HALF && addr[0])) begin
          res.mem_size = '0;
          res.trap_cause = (e_r.cls == CLS_STORE) ? TRAP_STORE_MIS : TRAP_LOAD_MIS;
          res.trap_value = addr;
        end else begin
          res.result_kind = 1'b1;
          res.mem_is_write = (e_r.cls == CLS_STORE);
          res.mem_address = addr;
          if (e_r.cls == CLS_STORE) begin
            res.mem_write_data = (res.mem_size == SIZE_WORD) ? b :
                                 (res.mem_size == SIZE_HALF) ? {16'd0, b[15:0]} :
                                 {24'd0, b[7:0]};
          end
          pend_v_nxt = 1'b1;
          pend_op_nxt = it.operation;
          pend_rd_nxt = it.dest_reg;
          pend_addr_nxt = addr;
        end
      end
      CLS_BRANCH: begin
        case (op)
          OP_BEQ:  taken = (a == b);
          OP_BNE:  taken = (a != b);
          OP_BLT:  taken = $signed(a) < $signed(b);
          OP_BGE:  taken = !($signed(a) < $signed(b));
          OP_BLTU: taken = a < b;
          default: taken = a >= b;
        endcase
        tgt = it.current_pc + it.immediate;
        if (taken) begin
          if (tgt[1:0] != 2'd0) begin
            res.trap_cause = TRAP_FETCH_MIS;
            res.trap_value = tgt;
          end else begin
            res.jump_valid = 1'b1;
            res.next_pc = tgt;
          end
        end
      end
      CLS_JUMP: begin
        tgt = (op == OP_JAL) ? it.current_pc + it.immediate : {addr[31:1], 1'b0};
        if (tgt[1:0] != 2'd0) begin
          res.trap_cause = TRAP_FETCH_MIS;
          res.trap_value = tgt;
        end else begin
          res.jump_valid = 1'b1;
          res.next_pc = tgt;
          wr_req = 1'b1;
          wr_data = it.current_pc + 32'd4;
        end
      end
      CLS_CSR: begin
        if (!ch.hit) begin
          res.trap_cause = TRAP_ILLEGAL;
          res.trap_value = it.instruction_word;
        end else begin
          immf = (op == OP_CSRRWI) || (op == OP_CSRRSI) || (op == OP_CSRRCI);
          src = immf ? {27'd0, it.src1_reg} : a;
          old = csr_r[csr_idx];
          wr_req = 1'b1;
          wr_data = old;
          if (op == OP_CSRRW || op == OP_CSRRWI) begin
            csr_we = 1'b1;
            csr_wdata = src;
          end else if (it.src1_reg != 5'd0) begin
            csr_we = 1'b1;
            csr_wdata = (op == OP_CSRRS || op == OP_CSRRSI) ? (old | src) : (old & ~src);
          end
        end
      end
      CLS_MRET: begin
        ms = (csr_r[0] & MSTATUS_MPIE) != '0 ? (csr_r[0] | MSTATUS_MIE) :
                                              (csr_r[0] & ~MSTATUS_MIE);
        ms_we = 1'b1;
        ms_wdata = ms | MSTATUS_MPIE;
        res.jump_valid = 1'b1;
        res.next_pc = csr_r[1];
      end
      CLS_SYS: begin
        if (op == OP_ECALL) begin
          res.trap_cause = TRAP_ECALL;
        end else if (op == OP_EBREAK) begin
          res.trap_cause = TRAP_BREAK;
          res.trap_value = it.current_pc;
        end
      end
      default: begin
        res.trap_cause = TRAP_ILLEGAL;
        res.trap_value = it.instruction_word;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      pend_v_r    <= 1'b0;
      pend_op_r   <= '0;
      pend_rd_r   <= '0;
      pend_addr_r <= '0;
      rfv_r       <= '0;
      for (int i = 0; i < CSR_COUNT; i++) csr_r[i] <= '0;
    end else begin
      if (q_pop) e_valid_r <= q_valid;
      if (out_free) out_valid_r <= e_valid_r;
      if (fire) begin
        pend_v_r    <= pend_v_nxt;
        pend_op_r   <= pend_op_nxt;
        pend_rd_r   <= pend_rd_nxt;
        pend_addr_r <= pend_addr_nxt;
        if (csr_we) csr_r[csr_idx] <= csr_wdata;
        if (ms_we) csr_r[0] <= ms_wdata;
      end
      if (wr_en) rfv_r[wr_idx[RW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) rf[wr_idx[RW-1:0]] <= wr_data;
    if (q_pop) begin
      e_r   <= q_item;
      rq1_r <= rf[q_item.item.src1_reg[RW-1:0]];
      rq2_r <= rf[q_item.item.src2_reg[RW-1:0]];
      vq1_r <= rfv_r[q_item.item.src1_reg[RW-1:0]];
      vq2_r <= rfv_r[q_item.item.src2_reg[RW-1:0]];
      by1_r <= wr_en && (wr_idx == q_item.item.src1_reg);
      by2_r <= wr_en && (wr_idx == q_item.item.src2_reg);
      byd_r <= wr_data;
    end
    if (fire) out_r <= res;
  end
endmodule

// ===== hdl/rv32i_zicsr_execute_unit.sv =====
`timescale 1ns / 1ps
// Execute stage for decoded RV32I, Zicsr and mret instructions.
// Requests arrive on in_ch: an instruction to execute, or the response to
// the memory access issued last. Each request yields one result on out_ch:
// a completion with optional jump target or trap, or a memory request.
// Both channels move a request when valid and ready are high at a clock edge.
// A request passes a two-entry queue, a register file read stage and an
// execute stage whose result is held in the output register.
// Throughput is one request per cycle while out_ch does not stall;
// register file writes are forwarded to the following instruction, so
// dependent instructions do not stall.
// When out_ch stalls, the output register holds its result, the execute
// stage holds, and the queue keeps accepting until both entries are full.
// Synchronous reset clears the register file valid bits (all registers read
// as zero), the CSRs, the pending memory access and all valid flags.
module rv32i_zicsr_execute_unit #(
  parameter int REG_COUNT = rvx_pkg::RegCountDefault,
  parameter int CSR_COUNT = rvx_pkg::CsrCountDefault
) (
  input logic      clk,
  input logic      rst_n,
  rvx_req_if.sink  in_ch,
  rvx_rsp_if.source out_ch
);
  import rvx_pkg::*;

  req_t  in_item;
  item_t q_item;
  rsp_t  rsp;
  logic  q_valid, q_pop;

  assign in_item = '{action: in_ch.action, operation: in_ch.operation,
                     dest_reg: in_ch.dest_reg, src1_reg: in_ch.src1_reg,
                     src2_reg: in_ch.src2_reg, immediate: in_ch.immediate,
                     csr_address: in_ch.csr_address,
                     instruction_word: in_ch.instruction_word,
                     current_pc: in_ch.current_pc,
                     mem_read_data: in_ch.mem_read_data,
                     mem_fault: in_ch.mem_fault};

  rvx_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_item(in_item), .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item)
  );

  rvx_back #(.REG_COUNT(REG_COUNT), .CSR_COUNT(CSR_COUNT)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_rsp(rsp)
  );

  assign out_ch.result_kind    = rsp.result_kind;
  assign out_ch.jump_valid     = rsp.jump_valid;
  assign out_ch.next_pc        = rsp.next_pc;
  assign out_ch.trap_cause     = rsp.trap_cause;
  assign out_ch.trap_value     = rsp.trap_value;
  assign out_ch.mem_is_write   = rsp.mem_is_write;
  assign out_ch.mem_size       = rsp.mem_size;
  assign out_ch.mem_address    = rsp.mem_address;
  assign out_ch.mem_write_data = rsp.mem_write_data;
endmodule

// ===== tb/sv/rv32i_zicsr_execute_unit_tb.sv =====
`timescale 1ns / 1ps
module rv32i_zicsr_execute_unit_tb;
  import rvx_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  rvx_req_if in_ch ();
  rvx_rsp_if out_ch ();

  rv32i_zicsr_execute_unit u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always #5 clk = ~clk;

  req_t pending_q[$];
  rsp_t expected_q[$];

  logic [31:0] regs [32];
  logic [31:0] csrs [8];
  logic        acc_valid;
  logic [5:0]  acc_op;
  logic [4:0]  acc_dest;
  logic [31:0] acc_addr;

  int errors = 0;
  int n_sent = 0;
  int n_seen = 0;
  int n_traps = 0;
  int n_mem = 0;
  int n_total = 0;
  int hold_cycles = 0;
  bit in_acc = 1'b0;

  function automatic logic [31:0] rreg(input logic [4:0] i);
    return (i == 0) ? 32'd0 : regs[i];
  endfunction

  function automatic void wreg(input logic [4:0] i, input logic [31:0] v);
    if (i != 0) regs[i] = v;
  endfunction

  function automatic int csr_index(input logic [11:0] a);
    for (int i = 0; i < 8; i++) if (CSR_MAP[i] == a) return i;
    return -1;
  endfunction

  function automatic logic slt(input logic [31:0] a, input logic [31:0] b);
    return $signed(a) < $signed(b);
  endfunction

  function automatic void jump_to(inout rsp_t r, input logic [31:0] t);
    if (t[1:0] != 2'b00) begin
      r.trap_cause = TRAP_FETCH_MIS;
      r.trap_value = t;
    end else begin
      r.jump_valid = 1'b1;
      r.next_pc = t;
    end
  endfunction

  function automatic void mem_issue(inout rsp_t r, input op_t op, input logic [4:0] rd,
                                    input logic wr, input logic [1:0] sz,
                                    input logic [31:0] addr, input logic [31:0] d);
    r.result_kind = 1'b1;
    r.mem_is_write = wr;
    r.mem_size = sz;
    r.mem_address = addr;
    r.mem_write_data = d;
    acc_valid = 1'b1;
    acc_op = op;
    acc_dest = rd;
    acc_addr = addr;
  endfunction

  function automatic rsp_t execute_request(input req_t q);
    rsp_t r;
    logic [31:0] a, b, addr, d, old, src, ms;
    logic taken, store, immf;
    int s;
    int kind;
    op_t op;
    r = '0;
    taken = 0;
    a = rreg(q.src1_reg);
    b = rreg(q.src2_reg);
    addr = a + q.immediate;
    op = op_t'(q.operation);
    if (q.action) begin
      if (acc_valid) begin
        store = acc_op == OP_SW || acc_op == OP_SB || acc_op == OP_SH;
        d = q.mem_read_data;
        acc_valid = 1'b0;
        if (q.mem_fault) begin
          r.trap_cause = store ? TRAP_STORE_FLT : TRAP_LOAD_FLT;
          r.trap_value = acc_addr;
        end else if (!store) begin
          case (acc_op)
            OP_LB: d = {{24{d[7]}}, d[7:0]};
            OP_LBU: d = {24'd0, d[7:0]};
            OP_LH: d = {{16{d[15]}}, d[15:0]};
            OP_LHU: d = {16'd0, d[15:0]};
            default: ;
          endcase
          wreg(acc_dest, d);
        end
      end
      return r;
    end
    if (q.operation > OP_MRET) begin
      r.trap_cause = TRAP_ILLEGAL;
      r.trap_value = q.instruction_word;
      return r;
    end
    case (op)
      OP_ADD: wreg(q.dest_reg, a + b);
      OP_ADDI: wreg(q.dest_reg, addr);
      OP_SUB: wreg(q.dest_reg, a - b);
      OP_XOR: wreg(q.dest_reg, a ^ b);
      OP_OR: wreg(q.dest_reg, a | b);
      OP_AND: wreg(q.dest_reg, a & b);
      OP_XORI: wreg(q.dest_reg, a ^ q.immediate);
      OP_ORI: wreg(q.dest_reg, a | q.immediate);
      OP_ANDI: wreg(q.dest_reg, a & q.immediate);
      OP_SLL: wreg(q.dest_reg, a << b[4:0]);
      OP_SRL: wreg(q.dest_reg, a >> b[4:0]);
      OP_SRA: wreg(q.dest_reg, $signed(a) >>> b[4:0]);
      OP_SLLI: wreg(q.dest_reg, a << q.immediate[4:0]);
      OP_SRLI: wreg(q.dest_reg, a >> q.immediate[4:0]);
      OP_SRAI: wreg(q.dest_reg, $signed(a) >>> q.immediate[4:0]);
      OP_SLT: wreg(q.dest_reg, {31'd0, slt(a, b)});
      OP_SLTU: wreg(q.dest_reg, {31'd0, a < b});
      OP_SLTI: wreg(q.dest_reg, {31'd0, slt(a, q.immediate)});
      OP_SLTIU: wreg(q.dest_reg, {31'd0, a < q.immediate});
      OP_LUI: wreg(q.dest_reg, q.immediate);
      OP_AUIPC: wreg(q.dest_reg, q.current_pc + q.immediate);
      OP_LW, OP_LH, OP_LHU, OP_LB, OP_LBU: begin
        if ((op == OP_LW && addr[1:0] != 0) ||
            ((op == OP_LH || op == OP_LHU) && addr[0])) begin
          r.trap_cause = TRAP_LOAD_MIS;
          r.trap_value = addr;
        end else begin
          mem_issue(r, op, q.dest_reg, 1'b0,
                    op == OP_LW ? SIZE_WORD :
                    (op == OP_LB || op == OP_LBU) ? SIZE_BYTE : SIZE_HALF, addr, 32'd0);
        end
      end
      OP_SW, OP_SH, OP_SB: begin
        if ((op == OP_SW && addr[1:0] != 0) || (op == OP_SH && addr[0])) begin
          r.trap_cause = TRAP_STORE_MIS;
          r.trap_value = addr;
        end else if (op == OP_SW) begin
          mem_issue(r, op, q.dest_reg, 1'b1, SIZE_WORD, addr, b);
        end else if (op == OP_SH) begin
          mem_issue(r, op, q.dest_reg, 1'b1, SIZE_HALF, addr, {16'd0, b[15:0]});
        end else begin
          mem_issue(r, op, q.dest_reg, 1'b1, SIZE_BYTE, addr, {24'd0, b[7:0]});
        end
      end
      OP_BEQ: taken = a == b;
      OP_BNE: taken = a != b;
      OP_BLT: taken = slt(a, b);
      OP_BGE: taken = !slt(a, b);
      OP_BLTU: taken = a < b;
      OP_BGEU: taken = a >= b;
      OP_JAL, OP_JALR: begin
        jump_to(r, op == OP_JAL ? q.current_pc + q.immediate : {addr[31:1], 1'b0});
        if (r.trap_cause == TRAP_NONE) wreg(q.dest_reg, q.current_pc + 32'd4);
      end
      OP_FENCE: ;
      OP_ECALL: r.trap_cause = TRAP_ECALL;
      OP_EBREAK: begin
        r.trap_cause = TRAP_BREAK;
        r.trap_value = q.current_pc;
      end
      OP_CSRRW, OP_CSRRS, OP_CSRRC, OP_CSRRWI, OP_CSRRSI, OP_CSRRCI: begin
        s = csr_index(q.csr_address);
        immf = op >= OP_CSRRWI;
        src = immf ? {27'd0, q.src1_reg} : a;
        kind = immf ? op - OP_CSRRWI : op - OP_CSRRW;
        if (s < 0) begin
          r.trap_cause = TRAP_ILLEGAL;
          r.trap_value = q.instruction_word;
        end else begin
          old = csrs[s];
          if (kind == 0) csrs[s] = src;
          else if (q.src1_reg != 0) csrs[s] = (kind == 1) ? (old | src) : (old & ~src);
          wreg(q.dest_reg, old);
        end
      end
      OP_MRET: begin
        ms = csrs[0];
        if ((ms & MSTATUS_MPIE) != 0) ms = ms | MSTATUS_MIE;
        else ms = ms & ~MSTATUS_MIE;
        csrs[0] = ms | MSTATUS_MPIE;
        r.jump_valid = 1'b1;
        r.next_pc = csrs[1];
      end
      default: ;
    endcase
    if (taken) jump_to(r, q.current_pc + q.immediate);
    return r;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return $urandom_range(0, 64);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [11:0] rand_csr();
    if ($urandom_range(0, 4) == 0) return 12'($urandom);
    return CSR_MAP[$urandom_range(0, 11)];
  endfunction

  function automatic req_t rand_instr(input logic [5:0] op);
    req_t q;
    q.action = 1'b0;
    q.operation = op;
    q.dest_reg = 5'($urandom);
    q.src1_reg = 5'($urandom);
    q.src2_reg = 5'($urandom);
    q.immediate = rand_word();
    q.csr_address = rand_csr();
    q.instruction_word = $urandom;
    q.current_pc = ($urandom_range(0, 3) == 0) ? rand_word() : {30'($urandom), 2'b00};
    q.mem_read_data = $urandom;
    q.mem_fault = 1'($urandom);
    return q;
  endfunction

  function automatic req_t mem_response(input logic fault);
    req_t q;
    q = rand_instr(6'($urandom));
    q.action = 1'b1;
    q.mem_read_data = rand_word();
    q.mem_fault = fault;
    return q;
  endfunction

  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_acc) begin
      if (pending_q.size() > 0 && $urandom_range(0, 9) < 7) begin
        in_ch.valid <= 1'b1;
        {in_ch.action, in_ch.operation, in_ch.dest_reg, in_ch.src1_reg, in_ch.src2_reg,
         in_ch.immediate, in_ch.csr_address, in_ch.instruction_word, in_ch.current_pc,
         in_ch.mem_read_data, in_ch.mem_fault} <= pending_q.pop_front();
      end else if ($urandom_range(0, 40) == 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(5, 30)) @(negedge clk);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 60) == 0) begin
      hold_cycles <= $urandom_range(10, 40);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= $urandom_range(0, 9) < 8;
    end
  end

  always @(posedge clk) begin
    req_t q;
    rsp_t got, want;
    in_acc = rst_n && in_ch.valid && in_ch.ready;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      q = {in_ch.action, in_ch.operation, in_ch.dest_reg, in_ch.src1_reg, in_ch.src2_reg,
           in_ch.immediate, in_ch.csr_address, in_ch.instruction_word, in_ch.current_pc,
           in_ch.mem_read_data, in_ch.mem_fault};
      want = execute_request(q);
      if (want.trap_cause != TRAP_NONE) n_traps++;
      if (want.result_kind) n_mem++;
      expected_q.push_back(want);
      n_sent++;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = {out_ch.result_kind, out_ch.jump_valid, out_ch.next_pc, out_ch.trap_cause,
             out_ch.trap_value, out_ch.mem_is_write, out_ch.mem_size, out_ch.mem_address,
             out_ch.mem_write_data};
      n_seen++;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected result %h", got);
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) begin
            $display("Mismatch on result %0d:", n_seen);
            $display("  expected kind=%b jmp=%b pc=%h trap=%0d val=%h w=%b sz=%0d a=%h d=%h",
                     want.result_kind, want.jump_valid, want.next_pc, want.trap_cause,
                     want.trap_value, want.mem_is_write, want.mem_size, want.mem_address,
                     want.mem_write_data);
            $display("  actual   kind=%b jmp=%b pc=%h trap=%0d val=%h w=%b sz=%0d a=%h d=%h",
                     got.result_kind, got.jump_valid, got.next_pc, got.trap_cause,
                     got.trap_value, got.mem_is_write, got.mem_size, got.mem_address,
                     got.mem_write_data);
          end
        end
      end
    end
  end

  initial begin
    req_t q;
    logic [5:0] op;
    in_ch.valid = 1'b0;
    {in_ch.action, in_ch.operation, in_ch.dest_reg, in_ch.src1_reg, in_ch.src2_reg,
     in_ch.immediate, in_ch.csr_address, in_ch.instruction_word, in_ch.current_pc,
     in_ch.mem_read_data, in_ch.mem_fault} = '0;
    out_ch.ready = 1'b0;
    for (int i = 0; i < 32; i++) regs[i] = '0;
    for (int i = 0; i < 8; i++) csrs[i] = '0;
    acc_valid = 0;
    acc_op = '0;
    acc_dest = '0;
    acc_addr = '0;

    // Directed part: stray response, seed registers, loads and stores, CSRs, mret, ecall, ebreak, illegal op, jal.
    pending_q.push_back(mem_response(1'b0));
    for (int i = 1; i < 6; i++) begin
      q = rand_instr(OP_LUI);
      q.dest_reg = 5'(i);
      q.immediate = (i == 1) ? 32'hFFFF_FFFF : (i == 2) ? 32'h8000_0000 : 32'(i * 4);
      pending_q.push_back(q);
    end
    q = rand_instr(OP_LW); q.src1_reg = 5'd3; q.immediate = 32'd1; pending_q.push_back(q);
    q = rand_instr(OP_LB); q.src1_reg = 5'd3; q.immediate = 32'd1; q.dest_reg = 5'd6;
    pending_q.push_back(q);
    q = mem_response(1'b0); q.mem_read_data = 32'h0000_0080; pending_q.push_back(q);
    q = rand_instr(OP_SW); q.src1_reg = 5'd4; q.immediate = 32'd0; q.src2_reg = 5'd1;
    pending_q.push_back(q);
    pending_q.push_back(mem_response(1'b1));
    q = rand_instr(OP_CSRRW); q.csr_address = 12'h341; q.src1_reg = 5'd4;
    pending_q.push_back(q);
    q = rand_instr(OP_CSRRSI); q.csr_address = 12'h300; q.src1_reg = 5'h1F;
    pending_q.push_back(q);
    pending_q.push_back(rand_instr(OP_MRET));
    pending_q.push_back(rand_instr(OP_ECALL));
    pending_q.push_back(rand_instr(OP_EBREAK));
    pending_q.push_back(rand_instr(6'd63));
    q = rand_instr(OP_JAL); q.immediate = 32'd2; pending_q.push_back(q);
    q = rand_instr(OP_CSRRC); q.csr_address = 12'hF11; pending_q.push_back(q);

    // Random part: random instructions, with most memory accesses paired with responses.
    for (int i = 0; i < 780; i++) begin
      op = ($urandom_range(0, 20) == 0) ? 6'($urandom_range(47, 63))
                                         : 6'($urandom_range(0, 46));
      q = rand_instr(op);
      if (op >= OP_LW && op <= OP_SH && $urandom_range(0, 2) != 0) q.immediate = '0;
      if ($urandom_range(0, 9) == 0) q.dest_reg = 5'd0;
      pending_q.push_back(q);
      if (op >= OP_LW && op <= OP_SH && $urandom_range(0, 5) != 0) begin
        pending_q.push_back(mem_response($urandom_range(0, 4) == 0));
        i++;
      end else if ($urandom_range(0, 30) == 0) begin
        pending_q.push_back(mem_response(1'($urandom)));
        i++;
      end
    end
    n_total = pending_q.size();

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Hold off the receiver so the block backs up and stalls its input.
    wait (n_sent > 40);
    @(posedge clk);
    hold_cycles = 60;

    wait (n_seen >= n_total);
    repeat (10) @(posedge clk);

    $display("Covered %0d requests, %0d results, %0d traps, %0d memory requests.",
             n_sent, n_seen, n_traps, n_mem);
    if (errors == 0 && expected_q.size() == 0 && n_sent == n_total) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches, %0d results outstanding.", errors, expected_q.size());
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timed out with %0d results outstanding.", expected_q.size());
    $display("FAILURE");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/rvx_pkg.sv
hdl/rvx_if.sv
hdl/rvx_front.sv
hdl/rvx_back.sv
hdl/rv32i_zicsr_execute_unit.sv
tb/sv/rv32i_zicsr_execute_unit_tb.sv
